@@ hw/rtl/can_signal_extractor_macros.svh @@
// assertion macros of the checker file of the signal extractor
`ifndef CAN_SIGNAL_EXTRACTOR_MACROS_SVH
`define CAN_SIGNAL_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CSE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cse_pkg.sv @@
// types, constants and the field extraction function of the can signal extractor
`default_nettype none

package cse_pkg;

  localparam int unsigned NUM_SIGNALS     = 7;
  localparam int unsigned MAX_FRAME_BYTES = 8;

  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned SIG_W     = 3;
  localparam int unsigned FBITS_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned MUXVAL_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_BYTES = 3'd0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  typedef struct packed {
    logic                enable;
    logic                rsvd;
    logic [MUXVAL_W-1:0] muxval;
    logic                hasmuxval;
    logic                ismux;
    logic [5:0]          cnt_m1;
    logic [5:0]          start;
  } desc_t;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] raw;
    status_e              status;
  } ext_t;

  function automatic ext_t extract(desc_t d, logic [PAYLOAD_W-1:0] pay,
                                   logic [FBITS_W-1:0] fbits);
    ext_t                 r;
    logic [FBITS_W-1:0]   cnt;
    logic [FBITS_W-1:0]   span;
    logic [PAYLOAD_W-1:0] mask;
    cnt  = {1'b0, d.cnt_m1} + 7'd1;
    span = {1'b0, d.start} + cnt;
    mask = ~({PAYLOAD_W{1'b1}} << cnt);
    if (span > fbits) begin
      r.raw    = '0;
      r.status = ST_OUTSIDE;
    end else begin
      r.raw    = (pay >> d.start) & mask;
      r.status = ST_OK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/can_signal_extractor.sv @@
// can signal extractor: per-frame raw field extraction over seven descriptors
//
// usage
//   frames enter on the s_axis channel, tdata = payload[63:0], frame_length[67:64]
//   results leave on the m_axis channel, one result per extracted signal;
//   tlast marks the final result of a frame, tuser flags the multiplexer result
//   registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
//   must write them only while idle, which the block itself leaves unchecked
// pipeline
//   frames pass the input register and the plan register, results the result register
// throughput
//   a frame of 0 to 7 results holds the emit stage until its last one is issued; the emit
//   extractor, shared by the non-mux signals, gives one result per cycle unless stalled
// reset
//   all channels empty, message_bytes = 8, all descriptors cleared (disabled)
// back pressure
//   a stalled result holds in the output register; the emit stage and the input
//   register keep filling, so s_axis_tready drops only when both are occupied
`default_nettype none

module can_signal_extractor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // cfg
  input  wire logic                          cfg_we_i,
  input  wire logic [cse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cse_pkg::CFG_W-1:0]     cfg_wdata_i,
  // frame input
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [71:0]                   s_axis_tdata,  // payload, frame_length
  // result output
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [71:0]                   m_axis_tdata,  // signal_index, raw_bits, status
  output      logic                          m_axis_tuser,  // is_mux_signal
  output      logic                          m_axis_tlast   // last_result
);
  import cse_pkg::*;

  // config registers
  logic [LEN_W-1:0] msg_bytes_q;
  desc_t            desc_q [NUM_SIGNALS];

  // input register
  logic                 s1_valid_q;
  logic [PAYLOAD_W-1:0] s1_pay_q;
  logic [LEN_W-1:0]     s1_len_q;

  // plan register
  logic                   busy_q;
  logic                   short_q;
  logic                   mux_pend_q;
  logic [SIG_W-1:0]       mux_idx_q;
  logic [PAYLOAD_W-1:0]   mux_raw_q;
  status_e                mux_st_q;
  logic [NUM_SIGNALS-1:0] pend_q, pend_d;
  logic [PAYLOAD_W-1:0]   pay_q;
  logic [FBITS_W-1:0]     fbits_q;

  // result register
  logic                 out_valid_q;
  logic [SIG_W-1:0]     out_idx_q;
  logic [PAYLOAD_W-1:0] out_raw_q;
  logic                 out_mux_q;
  status_e              out_st_q;
  logic                 out_last_q;

  // plan logic
  logic [LEN_W-1:0]       len_eff;
  logic [FBITS_W-1:0]     fbits;
  logic                   too_short;
  logic                   mux_found;
  logic [SIG_W-1:0]       mux_idx;
  desc_t                  mux_desc;
  ext_t                   mux_ext;
  logic [NUM_SIGNALS-1:0] plan_pend;

  // emit logic
  logic [SIG_W-1:0]     sel;
  ext_t                 sel_ext;
  logic                 e_has;
  logic [SIG_W-1:0]     e_idx;
  logic [PAYLOAD_W-1:0] e_raw;
  logic                 e_mux;
  status_e              e_st;
  logic                 e_last;
  logic                 emit_ready, emit_fire, s2_done, s2_free, s1_move;

  always_comb begin
    len_eff   = (s1_len_q > LEN_W'(MAX_FRAME_BYTES)) ? LEN_W'(MAX_FRAME_BYTES) : s1_len_q;
    fbits     = {len_eff, 3'b000};
    too_short = len_eff < msg_bytes_q;
    mux_found = 1'b0;
    mux_idx   = '0;
    mux_desc  = '0;
    for (int i = 0; i < NUM_SIGNALS; i++) begin
      if (!mux_found && desc_q[i].enable && desc_q[i].ismux) begin
        mux_found = 1'b1;
        mux_idx   = SIG_W'(i);
        mux_desc  = desc_q[i];
      end
    end
    mux_ext = extract(mux_desc, s1_pay_q, fbits);
    for (int i = 0; i < NUM_SIGNALS; i++) begin
      plan_pend[i] = desc_q[i].enable
                   && !(mux_found && (SIG_W'(i) == mux_idx))
                   && !(mux_found && desc_q[i].hasmuxval
                        && ({{(PAYLOAD_W-MUXVAL_W){1'b0}}, desc_q[i].muxval}
                            != mux_ext.raw));
    end
  end

  always_comb begin
    sel = '0;
    for (int i = NUM_SIGNALS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = SIG_W'(i);
      end
    end
    sel_ext = extract(desc_q[sel], pay_q, fbits_q);
    pend_d  = pend_q & ~(NUM_SIGNALS'(1) << sel);
    e_has   = 1'b0;
    e_idx   = '0;
    e_raw   = '0;
    e_mux   = 1'b0;
    e_st    = ST_OK;
    e_last  = 1'b0;
    if (short_q) begin
      e_has  = 1'b1;
      e_st   = ST_SHORT;
      e_last = 1'b1;
    end else if (mux_pend_q) begin
      e_has  = 1'b1;
      e_idx  = mux_idx_q;
      e_raw  = mux_raw_q;
      e_mux  = 1'b1;
      e_st   = mux_st_q;
      e_last = (pend_q == '0);
    end else if (pend_q != '0) begin
      e_has  = 1'b1;
      e_idx  = sel;
      e_raw  = sel_ext.raw;
      e_st   = sel_ext.status;
      e_last = (pend_d == '0);
    end
  end

  assign emit_ready    = !out_valid_q || m_axis_tready;
  assign emit_fire     = busy_q && e_has && emit_ready;
  assign s2_done       = busy_q && (!e_has || (emit_fire && e_last));
  assign s2_free       = !busy_q || s2_done;
  assign s1_move       = s1_valid_q && s2_free;
  assign s_axis_tready = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_bytes_q <= LEN_W'(MAX_FRAME_BYTES);
      for (int i = 0; i < NUM_SIGNALS; i++) begin
        desc_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MSG_BYTES: msg_bytes_q <= cfg_wdata_i[LEN_W-1:0];
        default:       desc_q[SIG_W'(cfg_idx_i - 3'd1)] <= desc_t'(cfg_wdata_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      busy_q      <= 1'b0;
      short_q     <= 1'b0;
      mux_pend_q  <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_move) begin
        busy_q     <= 1'b1;
        short_q    <= too_short;
        mux_pend_q <= !too_short && mux_found;
        pend_q     <= too_short ? '0 : plan_pend;
      end else begin
        if (s2_done) begin
          busy_q <= 1'b0;
        end
        if (emit_fire) begin
          if (short_q) begin
            short_q <= 1'b0;
          end else if (mux_pend_q) begin
            mux_pend_q <= 1'b0;
          end else begin
            pend_q <= pend_d;
          end
        end
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_pay_q <= s_axis_tdata[PAYLOAD_W-1:0];
      s1_len_q <= s_axis_tdata[PAYLOAD_W +: LEN_W];
    end
    if (s1_move) begin
      pay_q     <= s1_pay_q;
      fbits_q   <= fbits;
      mux_idx_q <= mux_idx;
      mux_raw_q <= mux_ext.raw;
      mux_st_q  <= mux_ext.status;
    end
    if (emit_fire) begin
      out_idx_q  <= e_idx;
      out_raw_q  <= e_raw;
      out_mux_q  <= e_mux;
      out_st_q   <= e_st;
      out_last_q <= e_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_st_q, out_raw_q, out_idx_q};
  assign m_axis_tuser  = out_mux_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/cse_checker.sv @@
// port-level checker of the can signal extractor and its bind
`default_nettype none

`include "can_signal_extractor_macros.svh"

module cse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [71:0] m_axis_tdata,  // signal_index, raw_bits, status
  input wire logic        m_axis_tuser,  // is_mux_signal
  input wire logic        m_axis_tlast   // last_result
);
  import cse_pkg::*;

  logic [SIG_W-1:0]     res_idx;
  logic [PAYLOAD_W-1:0] res_raw;
  logic [1:0]           res_st;
  logic [2:0]           res_pad;
  logic [73:0]          res_bus;
  logic                 res_stall;
  logic                 res_zero;
  logic                 is_short;
  logic                 is_outside;
  logic                 fields_ok;

  assign res_idx    = m_axis_tdata[2:0];
  assign res_raw    = m_axis_tdata[66:3];
  assign res_st     = m_axis_tdata[68:67];
  assign res_pad    = m_axis_tdata[71:69];
  assign res_bus    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign res_stall  = m_axis_tvalid && !m_axis_tready;
  assign res_zero   = (res_idx == '0) && (res_raw == '0);
  assign is_short   = m_axis_tvalid && (res_st == ST_SHORT);
  assign is_outside = m_axis_tvalid && (res_st == ST_OUTSIDE);
  assign fields_ok  = (res_st <= ST_SHORT) && (res_idx < SIG_W'(NUM_SIGNALS))
                   && (res_pad == '0);

  `CSE_ASSERT_NEXT(a_out_hold, res_stall, m_axis_tvalid && $stable(res_bus), "held result changed")

  `CSE_ASSERT(a_short_form, is_short, m_axis_tlast && !m_axis_tuser && res_zero, "bad short result")

  `CSE_ASSERT(a_outside_zero, is_outside, res_raw == '0, "outside-frame result carries data")

  `CSE_ASSERT(a_fields_legal, m_axis_tvalid, fields_ok, "result field out of range")

endmodule

bind can_signal_extractor cse_checker u_cse_checker (.*);

`default_nettype wire
